### rtl/core/ps2hbt_pkg.sv
package ps2hbt_pkg;

    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned CountW    = 4;

    localparam logic [CfgWidth-1:0] InhibitTicksRst   = 16'd120;
    localparam logic [CfgWidth-1:0] DataSetupTicksRst = 16'd10;
    localparam logic [CfgWidth-1:0] ReadLeadTicksRst  = 16'd50;
    localparam logic [CountW-1:0]   BitsPerByte       = 4'd8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INHIBIT_TICKS    = 2'd0,
        CFG_DATA_SETUP_TICKS = 2'd1,
        CFG_READ_LEAD_TICKS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RD_LEAD  = 4'd1,
        PH_RD_START = 4'd2,
        PH_RD_BITS  = 4'd3,
        PH_RD_PAR   = 4'd4,
        PH_RD_STOP  = 4'd5,
        PH_WR_INH   = 4'd6,
        PH_WR_SETUP = 4'd7,
        PH_WR_START = 4'd8,
        PH_WR_BITS  = 4'd9,
        PH_WR_STOP  = 4'd10,
        PH_WR_ACK   = 4'd11,
        PH_WR_END   = 4'd12
    } t_phase;

    typedef struct packed {
        logic [1:0]           req_type;
        logic                 clock_line;
        logic                 data_line;
        logic [ByteWidth-1:0] write_byte;
    } t_request;

    typedef struct packed {
        logic                 clock_drive_low;
        logic                 data_drive_low;
        logic                 busy_res;
        logic                 byte_valid;
        logic [ByteWidth-1:0] read_byte;
        logic                 parity_error;
        logic                 write_done;
        logic                 write_nack;
    } t_result;

endpackage

### rtl/core/ps2hbt_fsm.sv
module ps2hbt_fsm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ps2hbt_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [ps2hbt_pkg::CfgWidth-1:0]   i_cfg_data,
    input  logic                              i_accept,
    input  ps2hbt_pkg::t_request              i_request,
    output ps2hbt_pkg::t_result               o_result
);
    import ps2hbt_pkg::*;

    logic [CfgWidth-1:0]  r_inhibit_ticks;
    logic [CfgWidth-1:0]  r_data_setup_ticks;
    logic [CfgWidth-1:0]  r_read_lead_ticks;

    t_phase               r_phase, n_phase;
    logic [CountW-1:0]    r_bit_count, n_bit_count;
    logic [ByteWidth-1:0] r_shift_reg, n_shift_reg;
    logic                 r_ones_parity, n_ones_parity;
    logic                 r_prev_clock, n_prev_clock;
    logic [CfgWidth-1:0]  r_delay_count, n_delay_count;
    logic                 r_clock_hold, n_clock_hold;
    logic                 r_data_hold, n_data_hold;

    logic                 fall;
    logic [CfgWidth-1:0]  delay_limit;
    logic                 delay_hit;
    logic [CfgWidth-1:0]  delay_inc;
    logic                 drv_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inhibit_ticks    <= InhibitTicksRst;
            r_data_setup_ticks <= DataSetupTicksRst;
            r_read_lead_ticks  <= ReadLeadTicksRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INHIBIT_TICKS:    r_inhibit_ticks    <= i_cfg_data;
                CFG_DATA_SETUP_TICKS: r_data_setup_ticks <= i_cfg_data;
                CFG_READ_LEAD_TICKS:  r_read_lead_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_shift_reg   <= '0;
            r_ones_parity <= 1'b0;
            r_prev_clock  <= 1'b1;
            r_delay_count <= '0;
            r_clock_hold  <= 1'b1;
            r_data_hold   <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_shift_reg   <= n_shift_reg;
            r_ones_parity <= n_ones_parity;
            r_prev_clock  <= n_prev_clock;
            r_delay_count <= n_delay_count;
            r_clock_hold  <= n_clock_hold;
            r_data_hold   <= n_data_hold;
        end
    end

    assign fall      = r_prev_clock && !i_request.clock_line;
    assign delay_hit = (r_delay_count >= delay_limit);
    assign delay_inc = r_delay_count + CfgWidth'(1);
    assign drv_bit   = r_shift_reg[0];

    always_comb begin
        unique case (r_phase)
            PH_RD_LEAD:  delay_limit = r_read_lead_ticks;
            PH_WR_INH:   delay_limit = r_inhibit_ticks;
            default:     delay_limit = r_data_setup_ticks;
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shift_reg   = r_shift_reg;
        n_ones_parity = r_ones_parity;
        n_prev_clock  = i_request.clock_line;
        n_delay_count = r_delay_count;
        n_clock_hold  = r_clock_hold;
        n_data_hold   = r_data_hold;
        o_result      = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_request.req_type == REQ_READ) begin
                    n_clock_hold  = 1'b1;
                    n_data_hold   = 1'b0;
                    n_delay_count = '0;
                    n_phase       = PH_RD_LEAD;
                end else if (i_request.req_type == REQ_WRITE) begin
                    n_clock_hold  = 1'b1;
                    n_data_hold   = 1'b0;
                    n_delay_count = '0;
                    n_shift_reg   = i_request.write_byte;
                    n_phase       = PH_WR_INH;
                end
            end
            PH_RD_LEAD: begin
                if (delay_hit) begin
                    n_clock_hold = 1'b0;
                    n_phase      = PH_RD_START;
                end else begin
                    n_delay_count = delay_inc;
                end
            end
            PH_RD_START: begin
                if (fall) begin
                    n_bit_count   = '0;
                    n_shift_reg   = '0;
                    n_ones_parity = 1'b0;
                    n_phase       = PH_RD_BITS;
                end
            end
            PH_RD_BITS: begin
                if (fall) begin
                    n_shift_reg   = {i_request.data_line, r_shift_reg[ByteWidth-1:1]};
                    n_ones_parity = r_ones_parity ^ i_request.data_line;
                    n_bit_count   = r_bit_count + CountW'(1);
                    if (n_bit_count >= BitsPerByte) begin
                        n_phase = PH_RD_PAR;
                    end
                end
            end
            PH_RD_PAR: begin
                if (fall) begin
                    n_ones_parity = r_ones_parity ^ i_request.data_line;
                    n_phase       = PH_RD_STOP;
                end
            end
            PH_RD_STOP: begin
                if (fall) begin
                    n_clock_hold          = 1'b1;
                    o_result.byte_valid   = 1'b1;
                    o_result.read_byte    = r_shift_reg;
                    o_result.parity_error = !r_ones_parity;
                    n_phase               = PH_IDLE;
                end
            end
            PH_WR_INH: begin
                if (delay_hit) begin
                    n_data_hold   = 1'b1;
                    n_delay_count = '0;
                    n_phase       = PH_WR_SETUP;
                end else begin
                    n_delay_count = delay_inc;
                end
            end
            PH_WR_SETUP: begin
                if (delay_hit) begin
                    n_clock_hold = 1'b0;
                    n_phase      = PH_WR_START;
                end else begin
                    n_delay_count = delay_inc;
                end
            end
            PH_WR_START: begin
                if (fall) begin
                    n_data_hold   = !drv_bit;
                    n_ones_parity = drv_bit;
                    n_shift_reg   = {1'b0, r_shift_reg[ByteWidth-1:1]};
                    n_bit_count   = CountW'(1);
                    n_phase       = PH_WR_BITS;
                end
            end
            PH_WR_BITS: begin
                if (fall) begin
                    if (r_bit_count < BitsPerByte) begin
                        n_data_hold   = !drv_bit;
                        n_ones_parity = r_ones_parity ^ drv_bit;
                        n_shift_reg   = {1'b0, r_shift_reg[ByteWidth-1:1]};
                        n_bit_count   = r_bit_count + CountW'(1);
                    end else begin
                        n_data_hold = r_ones_parity;
                        n_phase     = PH_WR_STOP;
                    end
                end
            end
            PH_WR_STOP: begin
                if (fall) begin
                    n_data_hold = 1'b0;
                    n_phase     = PH_WR_ACK;
                end
            end
            PH_WR_ACK: begin
                if (fall) begin
                    if (i_request.data_line) begin
                        o_result.write_done = 1'b1;
                        o_result.write_nack = 1'b1;
                        n_phase             = PH_IDLE;
                    end else begin
                        n_phase = PH_WR_END;
                    end
                end
            end
            PH_WR_END: begin
                if (i_request.clock_line) begin
                    o_result.write_done = 1'b1;
                    n_phase             = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        o_result.clock_drive_low = n_clock_hold;
        o_result.data_drive_low  = n_data_hold;
        o_result.busy_res        = (n_phase != PH_IDLE);
    end

endmodule

### rtl/core/ps2hbt_out_reg.sv
module ps2hbt_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ps2hbt_pkg::t_result  i_result,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_can_load,
    output ps2hbt_pkg::t_result  o_result
);
    import ps2hbt_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/core/ps2_host_byte_transceiver_core.sv
// The result of an accepted request is computed combinationally and captured in the output register.
// One request per cycle when not stalled; the line state machine updates on accept.
// A result waiting in the output register does not block the next request unless it stalls.
// Reset is synchronous and active low; it restores the default timing registers,
// returns to idle with the clock line inhibited and data released, and empties the output.
module ps2_host_byte_transceiver_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ps2hbt_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [ps2hbt_pkg::CfgWidth-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_req_type,
    input  logic                                  i_clock_line,
    input  logic                                  i_data_line,
    input  logic [ps2hbt_pkg::ByteWidth-1:0]      i_write_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_clock_drive_low,
    output logic                                  o_data_drive_low,
    output logic                                  o_busy_res,
    output logic                                  o_byte_valid,
    output logic [ps2hbt_pkg::ByteWidth-1:0]      o_read_byte,
    output logic                                  o_parity_error,
    output logic                                  o_write_done,
    output logic                                  o_write_nack
);
    import ps2hbt_pkg::*;

    t_request request;
    t_result  step_result;
    t_result  held_result;
    logic     can_load;
    logic     accept;

    assign request.req_type   = i_req_type;
    assign request.clock_line = i_clock_line;
    assign request.data_line  = i_data_line;
    assign request.write_byte = i_write_byte;

    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    ps2hbt_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_request  (request),
        .o_result   (step_result)
    );

    ps2hbt_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (step_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_can_load  (can_load),
        .o_result    (held_result)
    );

    assign o_clock_drive_low = held_result.clock_drive_low;
    assign o_data_drive_low  = held_result.data_drive_low;
    assign o_busy_res        = held_result.busy_res;
    assign o_byte_valid      = held_result.byte_valid;
    assign o_read_byte       = held_result.read_byte;
    assign o_parity_error    = held_result.parity_error;
    assign o_write_done      = held_result.write_done;
    assign o_write_nack      = held_result.write_nack;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ps2hbt_pkg::*;

    localparam logic [1:0]          REQ_UNUSED  = 2'd3;
    localparam int unsigned         STALL_LIMIT = 2000;
    localparam int unsigned         PRINT_CAP   = 40;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CfgIdxW-1:0]   cfg_idx  = '0;
    logic [CfgWidth-1:0]  cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_request             tx_req   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 clk_drv;
    logic                 dat_drv;
    logic                 busy;
    logic                 byte_vld;
    logic [ByteWidth-1:0] rd_byte;
    logic                 par_err;
    logic                 wr_done;
    logic                 wr_nack;

    // Host line model: timing copy and transfer state.
    logic [CfgWidth-1:0]  inhibit_len;
    logic [CfgWidth-1:0]  setup_len;
    logic [CfgWidth-1:0]  lead_len;
    t_phase               line_phase;
    logic [CountW-1:0]    bit_cnt;
    logic [ByteWidth-1:0] shift_byte;
    logic                 ones_par;
    logic                 last_clock;
    logic [CfgWidth-1:0]  tick_cnt;
    logic                 hold_clock_low;
    logic                 hold_data_low;

    t_request    line_samples_q[$];
    t_result     line_states_due[$];
    int unsigned samples_queued = 0;
    int unsigned states_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned bytes_seen     = 0;
    int unsigned parity_flags   = 0;
    int unsigned writes_acked   = 0;
    int unsigned writes_nacked  = 0;
    int unsigned snd_idle_pct   = 0;
    int unsigned rcv_idle_pct   = 0;
    int unsigned quiet_cycles   = 0;

    ps2_host_byte_transceiver_core u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_req_type        (tx_req.req_type),
        .i_clock_line      (tx_req.clock_line),
        .i_data_line       (tx_req.data_line),
        .i_write_byte      (tx_req.write_byte),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_clock_drive_low (clk_drv),
        .o_data_drive_low  (dat_drv),
        .o_busy_res        (busy),
        .o_byte_valid      (byte_vld),
        .o_read_byte       (rd_byte),
        .o_parity_error    (par_err),
        .o_write_done      (wr_done),
        .o_write_nack      (wr_nack)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic delay_elapsed(input logic [CfgWidth-1:0] limit);
        if (tick_cnt >= limit) return 1'b1;
        tick_cnt = tick_cnt + CfgWidth'(1);
        return 1'b0;
    endfunction

    function automatic void send_next_bit();
        hold_data_low = ~shift_byte[0];
        ones_par      = ones_par ^ shift_byte[0];
        shift_byte    = shift_byte >> 1;
        bit_cnt       = bit_cnt + CountW'(1);
    endfunction

    function automatic t_result next_line_state(input t_request rq);
        t_result res;
        logic    fall;
        res  = '0;
        fall = last_clock & ~rq.clock_line;
        case (line_phase)
            PH_IDLE: begin
                if (rq.req_type == REQ_READ || rq.req_type == REQ_WRITE) begin
                    hold_clock_low = 1'b1;
                    hold_data_low  = 1'b0;
                    tick_cnt       = '0;
                    if (rq.req_type == REQ_READ) begin
                        line_phase = PH_RD_LEAD;
                    end else begin
                        shift_byte = rq.write_byte;
                        line_phase = PH_WR_INH;
                    end
                end
            end
            PH_RD_LEAD: begin
                if (delay_elapsed(lead_len)) begin
                    hold_clock_low = 1'b0;
                    line_phase     = PH_RD_START;
                end
            end
            PH_RD_START: begin
                if (fall) begin
                    bit_cnt    = '0;
                    shift_byte = '0;
                    ones_par   = 1'b0;
                    line_phase = PH_RD_BITS;
                end
            end
            PH_RD_BITS: begin
                if (fall) begin
                    shift_byte = {rq.data_line, shift_byte[ByteWidth-1:1]};
                    ones_par   = ones_par ^ rq.data_line;
                    bit_cnt    = bit_cnt + CountW'(1);
                    if (bit_cnt >= BitsPerByte) line_phase = PH_RD_PAR;
                end
            end
            PH_RD_PAR: begin
                if (fall) begin
                    ones_par   = ones_par ^ rq.data_line;
                    line_phase = PH_RD_STOP;
                end
            end
            PH_RD_STOP: begin
                if (fall) begin
                    hold_clock_low   = 1'b1;
                    res.byte_valid   = 1'b1;
                    res.read_byte    = shift_byte;
                    res.parity_error = ~ones_par;
                    line_phase       = PH_IDLE;
                end
            end
            PH_WR_INH: begin
                if (delay_elapsed(inhibit_len)) begin
                    hold_data_low = 1'b1;
                    tick_cnt      = '0;
                    line_phase    = PH_WR_SETUP;
                end
            end
            PH_WR_SETUP: begin
                if (delay_elapsed(setup_len)) begin
                    hold_clock_low = 1'b0;
                    line_phase     = PH_WR_START;
                end
            end
            PH_WR_START: begin
                if (fall) begin
                    bit_cnt  = '0;
                    ones_par = 1'b0;
                    send_next_bit();
                    line_phase = PH_WR_BITS;
                end
            end
            PH_WR_BITS: begin
                if (fall) begin
                    if (bit_cnt < BitsPerByte) begin
                        send_next_bit();
                    end else begin
                        // Odd parity: the bit is released when the count of ones is even.
                        hold_data_low = ones_par;
                        line_phase    = PH_WR_STOP;
                    end
                end
            end
            PH_WR_STOP: begin
                if (fall) begin
                    hold_data_low = 1'b0;
                    line_phase    = PH_WR_ACK;
                end
            end
            PH_WR_ACK: begin
                if (fall) begin
                    if (rq.data_line) begin
                        res.write_done = 1'b1;
                        res.write_nack = 1'b1;
                        line_phase     = PH_IDLE;
                    end else begin
                        line_phase = PH_WR_END;
                    end
                end
            end
            PH_WR_END: begin
                if (rq.clock_line) begin
                    res.write_done = 1'b1;
                    line_phase     = PH_IDLE;
                end
            end
            default: line_phase = PH_IDLE;
        endcase
        last_clock          = rq.clock_line;
        res.clock_drive_low = hold_clock_low;
        res.data_drive_low  = hold_data_low;
        res.busy_res        = (line_phase != PH_IDLE);
        return res;
    endfunction

    task automatic log_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
        if (mismatches < PRINT_CAP) begin
            $display("%0t: result %0d: %s expected %h, got %h",
                     $time, states_checked, what, want, got);
        end
        mismatches++;
    endtask

    function automatic logic [1:0] sample_req(input bit strays);
        if (strays && $urandom_range(11) == 0) return 2'($urandom_range(3, 1));
        return REQ_TICK;
    endfunction

    task automatic push_sample(input logic [1:0] req, input logic clk_lvl, input logic dat_lvl,
                               input logic [ByteWidth-1:0] wbyte);
        t_request s;
        s.req_type   = req;
        s.clock_line = clk_lvl;
        s.data_line  = dat_lvl;
        s.write_byte = wbyte;
        line_samples_q.push_back(s);
        samples_queued++;
    endtask

    task automatic push_level(input int n, input logic clk_lvl, input bit strays);
        repeat (n) push_sample(sample_req(strays), clk_lvl, 1'($urandom), 8'($urandom));
    endtask

    task automatic push_clock_cell(input logic dat_lvl, input bit strays);
        repeat ($urandom_range(2, 1)) push_sample(sample_req(strays), 1'b0, dat_lvl, 8'($urandom));
        repeat ($urandom_range(3, 1)) push_sample(sample_req(strays), 1'b1, dat_lvl, 8'($urandom));
    endtask

    task automatic push_noise(input int n);
        repeat (n) push_sample(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic push_read(input logic [ByteWidth-1:0] value, input bit bad_parity,
                             input logic stop_lvl, input bit strays, input int slack);
        logic par_bit;
        par_bit = ~^value ^ bad_parity;
        push_sample(REQ_READ, 1'b1, 1'b1, 8'($urandom));
        push_level(int'(lead_len) + 1 + slack, 1'b0, strays);
        push_level($urandom_range(2, 1), 1'b1, strays);
        push_clock_cell(1'b0, strays);
        for (int i = 0; i < ByteWidth; i++) push_clock_cell(value[i], strays);
        push_clock_cell(par_bit, strays);
        push_clock_cell(stop_lvl, 1'b0);
    endtask

    task automatic push_write(input logic [ByteWidth-1:0] value, input logic ack_lvl,
                              input bit strays, input int slack);
        push_sample(REQ_WRITE, 1'b1, 1'b1, value);
        push_level(int'(inhibit_len) + 1 + slack, 1'b0, strays);
        push_level(int'(setup_len) + 1, 1'b0, strays);
        push_level($urandom_range(2, 1), 1'b1, strays);
        repeat (ByteWidth + 2) push_clock_cell(1'($urandom), strays);
        push_clock_cell(ack_lvl, 1'b0);
    endtask

    task automatic push_random_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = samples_queued + budget;
        while (samples_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 42) begin
                push_read(8'($urandom), $urandom_range(5) == 0, $urandom_range(7) != 0,
                          $urandom_range(3) == 0, $urandom_range(2));
            end else if (pick < 84) begin
                push_write(8'($urandom), $urandom_range(4) == 0, $urandom_range(3) == 0,
                           $urandom_range(2));
            end else if (pick < 92) begin
                if ($urandom_range(1)) begin
                    push_read(8'($urandom), 1'b0, 1'b1, 1'b1, -int'($urandom_range(2, 1)));
                end else begin
                    push_write(8'($urandom), 1'b0, 1'b1, -int'($urandom_range(2, 1)));
                end
            end else begin
                push_noise($urandom_range(12, 1));
            end
            push_level($urandom_range(3), 1'($urandom), 1'b0);
        end
    endtask

    // Waits for every result, then clocks the lines until the transfer in flight ends.
    task automatic settle();
        wait (states_checked == samples_queued);
        while (line_phase != PH_IDLE) begin
            push_clock_cell(1'b0, 1'b0);
            wait (states_checked == samples_queued);
        end
    endtask

    task automatic write_timing(input t_cfg_idx idx, input logic [CfgWidth-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_INHIBIT_TICKS:    inhibit_len = value;
            CFG_DATA_SETUP_TICKS: setup_len   = value;
            default:              lead_len    = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(input logic [CfgWidth-1:0] inh, input logic [CfgWidth-1:0] setup,
                              input logic [CfgWidth-1:0] lead);
        write_timing(CFG_INHIBIT_TICKS, inh);
        write_timing(CFG_DATA_SETUP_TICKS, setup);
        write_timing(CFG_READ_LEAD_TICKS, lead);
    endtask

    function automatic logic [CfgWidth-1:0] short_delay();
        if ($urandom_range(4) == 0) return CfgWidth'($urandom_range(40));
        return CfgWidth'($urandom_range(6));
    endfunction

    task automatic set_pacing(input int unsigned snd, input int unsigned rcv);
        @(posedge clk);
        snd_idle_pct <= snd;
        rcv_idle_pct <= rcv;
    endtask

    // A request is taken at an edge where valid and ready are both high.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                line_states_due.push_back(next_line_state(tx_req));
            end
            if (!in_valid || in_ready) begin
                if (line_samples_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    tx_req   <= line_samples_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got.clock_drive_low = clk_drv;
                got.data_drive_low  = dat_drv;
                got.busy_res        = busy;
                got.byte_valid      = byte_vld;
                got.read_byte       = rd_byte;
                got.parity_error    = par_err;
                got.write_done      = wr_done;
                got.write_nack      = wr_nack;
                states_checked++;
                if (line_states_due.size() == 0) begin
                    log_mismatch("result without a pending request", 8'h00, 8'h01);
                end else begin
                    want = line_states_due.pop_front();
                    if (got.clock_drive_low !== want.clock_drive_low)
                        log_mismatch("clock_drive_low", 8'(want.clock_drive_low),
                                     8'(got.clock_drive_low));
                    if (got.data_drive_low !== want.data_drive_low)
                        log_mismatch("data_drive_low", 8'(want.data_drive_low),
                                     8'(got.data_drive_low));
                    if (got.busy_res !== want.busy_res)
                        log_mismatch("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    if (got.byte_valid !== want.byte_valid)
                        log_mismatch("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
                    if (got.read_byte !== want.read_byte)
                        log_mismatch("read_byte", want.read_byte, got.read_byte);
                    if (got.parity_error !== want.parity_error)
                        log_mismatch("parity_error", 8'(want.parity_error),
                                     8'(got.parity_error));
                    if (got.write_done !== want.write_done)
                        log_mismatch("write_done", 8'(want.write_done), 8'(got.write_done));
                    if (got.write_nack !== want.write_nack)
                        log_mismatch("write_nack", 8'(want.write_nack), 8'(got.write_nack));
                end
                bytes_seen    += 32'(got.byte_valid === 1'b1);
                parity_flags  += 32'(got.byte_valid === 1'b1 && got.parity_error === 1'b1);
                writes_acked  += 32'(got.write_done === 1'b1 && got.write_nack === 1'b0);
                writes_nacked += 32'(got.write_done === 1'b1 && got.write_nack === 1'b1);
            end
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        inhibit_len    = InhibitTicksRst;
        setup_len      = DataSetupTicksRst;
        lead_len       = ReadLeadTicksRst;
        line_phase     = PH_IDLE;
        bit_cnt        = '0;
        shift_byte     = '0;
        ones_par       = 1'b0;
        last_clock     = 1'b1;
        tick_cnt       = '0;
        hold_clock_low = 1'b1;
        hold_data_low  = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        set_pacing(15, 60);

        // Reset timing first, then the zero delays and the corner cases.
        push_read(8'h00, 1'b0, 1'b1, 1'b0, 0);
        push_write(8'h80, 1'b0, 1'b0, 0);
        settle();
        set_timing('0, '0, '0);
        push_sample(REQ_UNUSED, 1'b1, 1'b1, 8'hFF);
        push_sample(REQ_TICK, 1'b0, 1'b0, 8'h00);
        push_read(8'hFF, 1'b1, 1'b1, 1'b0, 0);
        push_read(8'hA5, 1'b0, 1'b0, 1'b1, 0);
        push_write(8'h01, 1'b1, 1'b0, 0);
        push_write(8'h5A, 1'b0, 1'b1, 0);
        push_write(8'hFF, 1'b0, 1'b0, 2);
        settle();

        set_timing(short_delay(), short_delay(), short_delay());
        push_random_traffic(280);
        settle();

        set_pacing(60, 15);
        repeat (2) begin
            set_timing(short_delay(), short_delay(), short_delay());
            push_random_traffic(140);
            settle();
        end

        set_pacing(0, 0);
        repeat (2) begin
            set_timing(short_delay(), short_delay(), short_delay());
            push_random_traffic(145);
            settle();
        end
        repeat (4) @(posedge clk);

        if (line_states_due.size() != 0) begin
            log_mismatch("results never delivered", 8'h00, 8'(line_states_due.size()));
        end
        $display("Run covered %0d line samples over reset, zero and random timing.",
                 samples_queued);
        $display("Bytes read: %0d (%0d with bad parity); writes acknowledged: %0d, refused: %0d.",
                 bytes_seen, parity_flags, writes_acked, writes_nacked);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
